// ----- rtl/core/hkoc_pkg.sv -----
package hkoc_pkg;

    localparam int KEY_WORD_W = 64;
    localparam int KEY_WORDS  = 4;
    localparam int KEY_W      = KEY_WORD_W * KEY_WORDS;
    localparam int TAG_W      = 8;
    localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;

    localparam int LIMIT_W                 = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd2867;

    localparam int OUTCOME_W   = 2;
    localparam int SLOT_OUT_W  = 12;
    localparam int OCC_OUT_W   = 32;
    localparam int TOTAL_OUT_W = 13;
    localparam int OUT_FIELD_W = SLOT_OUT_W + OCC_OUT_W + TOTAL_OUT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [KEY_WORD_W-1:0] HASH_MULT = 64'hbf58476d1ce4e5b9;
    localparam int HASH_SHIFT_A = 30;
    localparam int HASH_SHIFT_B = 27;
    localparam int HASH_OUT_W   = 32;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NEW     = 2'd0,
        OUT_COUNTED = 2'd1,
        OUT_FULL    = 2'd2
    } outcome_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } item_t;

    typedef struct packed {
        outcome_t                 outcome;
        logic [SLOT_OUT_W-1:0]    slot;
        logic [OCC_OUT_W-1:0]     occ;
        logic [TOTAL_OUT_W-1:0]   total;
    } res_t;

endpackage

// ----- rtl/core/hkoc_ram.sv -----
module hkoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/hkoc_hash.sv -----
module hkoc_hash #(
    parameter int SLOT_W = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [hkoc_pkg::KEY_WORD_W-1:0]    word,
    output logic                               done,
    output logic [SLOT_W-1:0]                  home
);

    import hkoc_pkg::*;

    localparam logic [1:0] STEP_LOW     = 2'd0;
    localparam logic [1:0] STEP_CROSS_A = 2'd1;
    localparam logic [1:0] STEP_CROSS_B = 2'd2;
    localparam logic [1:0] STEP_DONE    = 2'd3;

    logic                  busy_reg, busy_next;
    logic [1:0]            step_reg, step_next;
    logic [KEY_WORD_W-1:0] mix_reg, mix_next;
    logic [KEY_WORD_W-1:0] acc_reg, acc_next;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           product;
    logic [HASH_OUT_W-1:0] hash32;

    // one shared 32x32 multiplier, three passes for the low 64 bits of the product
    assign product = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        mul_a = mix_reg[31:0];
        mul_b = HASH_MULT[31:0];
        unique case (step_reg)
            STEP_CROSS_A:
            begin
                mul_a = mix_reg[63:32];
            end
            STEP_CROSS_B:
            begin
                mul_b = HASH_MULT[63:32];
            end
            STEP_LOW, STEP_DONE:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        mix_next  = mix_reg;
        acc_next  = acc_reg;
        done      = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = STEP_LOW;
                mix_next  = word ^ (word >> HASH_SHIFT_A);
            end
        end
        else
        begin
            unique case (step_reg)
                STEP_LOW:
                begin
                    acc_next  = product;
                    step_next = STEP_CROSS_A;
                end
                STEP_CROSS_A:
                begin
                    acc_next[63:32] = acc_reg[63:32] + product[31:0];
                    step_next       = STEP_CROSS_B;
                end
                STEP_CROSS_B:
                begin
                    acc_next[63:32] = acc_reg[63:32] + product[31:0];
                    step_next       = STEP_DONE;
                end
                STEP_DONE:
                begin
                    done      = 1'b1;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // low 32 bits of x ^ (x >> 27)
    assign hash32 = acc_reg[HASH_OUT_W-1:0] ^ acc_reg[HASH_SHIFT_B +: HASH_OUT_W];
    assign home   = hash32[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_LOW;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg <= mix_next;
        acc_reg <= acc_next;
    end

endmodule

// ----- rtl/core/hkoc_probe.sv -----
module hkoc_probe #(
    parameter int TABLE_SLOTS = 4096,
    parameter int COUNT_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  hkoc_pkg::item_t              item,
    input  logic [hkoc_pkg::LIMIT_W-1:0] limit,
    output logic                         ready,
    output logic                         res_valid,
    output hkoc_pkg::res_t               res,
    input  logic                         res_take
);

    import hkoc_pkg::*;

    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int DW        = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W     = (DW > LIMIT_W) ? DW : LIMIT_W;
    localparam int KEY_LSB   = 1;
    localparam int TAG_LSB   = KEY_LSB + KEY_W;
    localparam int COUNT_LSB = TAG_LSB + TAG_W;
    localparam int ROW_W     = COUNT_LSB + COUNT_BITS;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     clr_reg, clr_next;
    logic [SLOT_W-1:0]     probe_reg, probe_next;
    logic [SLOT_W-1:0]     dist_reg, dist_next;
    logic [DW-1:0]         distinct_reg, distinct_next;
    item_t                 item_reg, item_next;
    res_t                  res_reg, res_next;

    logic                  hash_done;
    logic [SLOT_W-1:0]     home;

    logic                  wr_en, rd_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [ROW_W-1:0]      wr_data, rd_data;

    logic                  row_valid;
    logic [KEY_W-1:0]      row_key;
    logic [COUNT_BITS-1:0] row_count, count_inc;
    logic                  room;
    logic [DW-1:0]         distinct_inc;

    logic [SLOT_W+SLOT_OUT_W-1:0]     slot_ext;
    logic [COUNT_BITS+OCC_OUT_W-1:0]  occ_new_ext, occ_inc_ext;
    logic [DW+TOTAL_OUT_W-1:0]        total_ext, total_inc_ext;

    hkoc_hash #(
        .SLOT_W (SLOT_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && state_reg == ST_IDLE),
        .word  (item.key[KEY_WORD_W-1:0]),
        .done  (hash_done),
        .home  (home)
    );

    hkoc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (probe_reg),
        .rd_data (rd_data)
    );

    assign row_valid = rd_data[0];
    assign row_key   = rd_data[KEY_LSB +: KEY_W];
    assign row_count = rd_data[COUNT_LSB +: COUNT_BITS];
    assign count_inc = (row_count == {COUNT_BITS{1'b1}}) ? row_count
                                                         : row_count + COUNT_BITS'(1);
    assign room         = CMP_W'(distinct_reg) < CMP_W'(limit);
    assign distinct_inc = distinct_reg + DW'(1);

    assign slot_ext      = {{SLOT_OUT_W{1'b0}}, probe_reg};
    assign occ_new_ext   = (COUNT_BITS + OCC_OUT_W)'(1);
    assign occ_inc_ext   = {{OCC_OUT_W{1'b0}}, count_inc};
    assign total_ext     = {{TOTAL_OUT_W{1'b0}}, distinct_reg};
    assign total_inc_ext = {{TOTAL_OUT_W{1'b0}}, distinct_inc};

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        probe_next    = probe_reg;
        dist_next     = dist_reg;
        distinct_next = distinct_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = probe_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero rows one per cycle so every slot starts empty
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + SLOT_W'(1);
                if (clr_reg == {SLOT_W{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    probe_next = home;
                    dist_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                res_next.outcome = OUT_FULL;
                res_next.slot    = '0;
                res_next.occ     = '0;
                res_next.total   = total_ext[TOTAL_OUT_W-1:0];
                state_next       = ST_OUT;
                if (!row_valid)
                begin
                    if (room)
                    begin
                        wr_en            = 1'b1;
                        wr_data          = {COUNT_BITS'(1), item_reg.tag, item_reg.key, 1'b1};
                        distinct_next    = distinct_inc;
                        res_next.outcome = OUT_NEW;
                        res_next.slot    = slot_ext[SLOT_OUT_W-1:0];
                        res_next.occ     = occ_new_ext[OCC_OUT_W-1:0];
                        res_next.total   = total_inc_ext[TOTAL_OUT_W-1:0];
                    end
                end
                else if (row_key == item_reg.key)
                begin
                    // tag stays as first written
                    wr_en            = 1'b1;
                    wr_data          = {count_inc, rd_data[COUNT_LSB-1:0]};
                    res_next.outcome = OUT_COUNTED;
                    res_next.slot    = slot_ext[SLOT_OUT_W-1:0];
                    res_next.occ     = occ_inc_ext[OCC_OUT_W-1:0];
                end
                else if (dist_reg != {SLOT_W{1'b1}})
                begin
                    probe_next = probe_reg + SLOT_W'(1);
                    dist_next  = dist_reg + SLOT_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            distinct_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            distinct_reg <= distinct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg <= probe_next;
        dist_reg  <= dist_next;
        item_reg  <= item_next;
        res_reg   <= res_next;
    end

endmodule

// ----- rtl/core/hashed_key_occurrence_counter.sv -----
// Hashed key occurrence counter: counts how often each 256-bit key is seen.
// Input stream s_*: one request per key, tdata holds the key (word 0 lowest),
// tuser the tag kept with a newly inserted key. Output stream m_*: one result
// per request, in order; tuser is the outcome (new, counted, refused), tdata
// holds slot, occurrences and the distinct-key total.
// cfg_*: writes the distinct-key limit (reset 2867); cfg_ready is always high.
// The home slot comes from a 64-bit multiply hash done in three passes of one
// 32x32 multiplier; the table is then probed linearly on a single table RAM,
// each slot with a memory read, then compare and write back.
// A request is processed until its result is handed to the output register
// before the next request is accepted.
// After reset the table is cleared one row per cycle, during which s_tready
// stays low; configuration writes are taken meanwhile.
// A finished result waits in the output register while m_tready is low and
// the next request is already processed; it waits at its end if the output
// register is still full.
module hashed_key_occurrence_counter #(
    parameter int TABLE_SLOTS = 4096,
    parameter int COUNT_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key_word0, key_word1, key_word2, key_word3
    input  logic [hkoc_pkg::IN_DATA_W-1:0]  s_tdata,
    // tag
    input  logic [hkoc_pkg::TAG_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot, occurrences, distinct_total, zero pad
    output logic [hkoc_pkg::OUT_DATA_W-1:0] m_tdata,
    // outcome
    output logic [hkoc_pkg::OUTCOME_W-1:0]  m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hkoc_pkg::LIMIT_W-1:0]    cfg_data
);

    import hkoc_pkg::*;

    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUTCOME_W-1:0]  m_tuser_reg;
    item_t                 item;
    res_t                  res;
    logic                  probe_ready, res_valid, res_take, load;

    assign item.key = s_tdata[KEY_W-1:0];
    assign item.tag = s_tuser;

    hkoc_probe #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_probe (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid),
        .item      (item),
        .limit     (limit_reg),
        .ready     (probe_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    assign s_tready  = probe_ready;
    assign cfg_ready = 1'b1;

    assign res_take = !m_tvalid_reg || m_tready;
    assign load     = res_valid && res_take;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end
        m_tvalid_next = m_tvalid_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= LIMIT_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= OUT_DATA_W'({res.total, res.occ, res.slot});
            m_tuser_reg <= res.outcome;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- rtl/core/hkoc_checker.sv -----
module hkoc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hkoc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [hkoc_pkg::OUTCOME_W-1:0]  m_tuser
);

    import hkoc_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one request in flight: ready drops right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    // a refused key reports no slot and no count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == OUT_FULL |-> m_tdata[SLOT_OUT_W+OCC_OUT_W-1:0] == '0)
        else $error("refused result carries slot or count");

    // a newly inserted key has been seen once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == OUT_NEW |->
            m_tdata[SLOT_OUT_W +: OCC_OUT_W] == OCC_OUT_W'(1))
        else $error("new key with count other than one");

endmodule

bind hashed_key_occurrence_counter hkoc_checker u_checker (.*);
